// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the framer modules.
// No dependencies; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

// ===== hdl/lcdfr_pkg.sv =====
// Package for the memory LCD line framer: codes, job descriptor and helpers.
// No dependencies; imported by every framer module.
package lcdfr_pkg;

    localparam int MAX_LINES       = 255;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CODE_WRITE = 8'h80;
    localparam logic [7:0] CODE_CLEAR = 8'h20;
    localparam logic [7:0] CODE_DUMMY = 8'h00;

    localparam logic [7:0] LINE_BYTES_RST   = 8'd50;
    localparam logic [7:0] PANEL_HEIGHT_RST = 8'd240;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_START = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_LINE_BYTES   = 1'b0,
        REG_PANEL_HEIGHT = 1'b1
    } cfg_reg_t;

    // What the back part has to emit for one accepted item.
    typedef enum logic [2:0] {
        JOB_FAIL     = 3'd0,
        JOB_CLEAR    = 3'd1,
        JOB_START    = 3'd2,
        JOB_PIX      = 3'd3,
        JOB_PIX_NEXT = 3'd4,
        JOB_PIX_END  = 3'd5
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        status_t     status;
        logic [7:0]  data;   // pixel byte
        logic [7:0]  addr;   // bit-reversed gate address
    } job_t;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    // Number of results a job produces.
    function automatic logic [1:0] job_len(input job_kind_t kind);
        logic [1:0] n;
        unique case (kind)
            JOB_FAIL, JOB_PIX:        n = 2'd1;
            JOB_CLEAR, JOB_START:     n = 2'd2;
            JOB_PIX_NEXT, JOB_PIX_END: n = 2'd3;
            default:                  n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/lcdfr_front.sv =====
// Front part of the framer: configuration registers, update state and command checks.
// Depends on lcdfr_pkg and assert_macros.svh; pushes one job per item into the queue.
`include "assert_macros.svh"

module lcdfr_front
    import lcdfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_t        in_cmd,
    input  logic [15:0] in_region_x,
    input  logic [15:0] in_region_w,
    input  logic [7:0]  in_start_line,
    input  logic [7:0]  in_line_count,
    input  logic [15:0] in_byte_total,
    input  logic [7:0]  in_pixel_byte,
    input  logic        full,
    output logic        push,
    output job_t        push_job
);

    logic [7:0] line_bytes_reg, line_bytes_next;
    logic [7:0] panel_height_reg, panel_height_next;
    logic       updating_reg, updating_next;
    logic [7:0] current_line_reg, current_line_next;
    logic [7:0] lines_left_reg, lines_left_next;
    logic [7:0] byte_in_line_reg, byte_in_line_next;

    logic [8:0]  span;
    logic [15:0] product;
    logic        width_ok;
    logic [7:0]  byte_inc;
    logic [7:0]  lines_dec;
    job_t        job;

    assign in_ready = !full;
    assign push     = in_valid && in_ready;
    assign push_job = job;

    assign span     = {1'b0, in_start_line} + {1'b0, in_line_count};
    assign product  = {8'd0, in_line_count} * {8'd0, line_bytes_reg};
    assign width_ok = (in_region_x == 16'd0) &&
                      (in_region_w == {5'd0, line_bytes_reg, 3'd0});
    assign byte_inc  = byte_in_line_reg + 8'd1;
    assign lines_dec = lines_left_reg - 8'd1;

    always_comb
    begin
        line_bytes_next   = line_bytes_reg;
        panel_height_next = panel_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LINE_BYTES:   line_bytes_next   = cfg_data;
                REG_PANEL_HEIGHT: panel_height_next = cfg_data;
                default:          line_bytes_next   = line_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        job.kind          = JOB_FAIL;
        job.status        = ST_INVALID;
        job.data          = in_pixel_byte;
        job.addr          = flip8(in_start_line + 8'd1);
        updating_next     = updating_reg;
        current_line_next = current_line_reg;
        lines_left_next   = lines_left_reg;
        byte_in_line_next = byte_in_line_reg;

        unique case (in_cmd)
            CMD_CLEAR:
            begin
                if (!updating_reg)
                begin
                    job.kind   = JOB_CLEAR;
                    job.status = ST_OK;
                end
            end
            CMD_START:
            begin
                priority if (updating_reg)
                    job.status = ST_INVALID;
                else if (in_line_count == 8'd0 || {1'b0, in_line_count} > 9'(MAX_LINES))
                    job.status = ST_INVALID;
                else if (line_bytes_reg == 8'd0)
                    job.status = ST_INVALID;
                else if (!width_ok)
                    job.status = ST_UNSUPPORTED;
                else if (span > {1'b0, panel_height_reg})
                    job.status = ST_INVALID;
                else if (in_byte_total != product)
                    job.status = ST_INVALID;
                else
                begin
                    job.kind          = JOB_START;
                    job.status        = ST_OK;
                    updating_next     = 1'b1;
                    current_line_next = in_start_line;
                    lines_left_next   = in_line_count;
                    byte_in_line_next = 8'd0;
                end
            end
            CMD_PIXEL:
            begin
                if (updating_reg)
                begin
                    job.status = ST_OK;
                    if (byte_inc < line_bytes_reg)
                    begin
                        job.kind          = JOB_PIX;
                        byte_in_line_next = byte_inc;
                    end
                    else
                    begin
                        byte_in_line_next = 8'd0;
                        lines_left_next   = lines_dec;
                        current_line_next = current_line_reg + 8'd1;
                        job.addr          = flip8(current_line_reg + 8'd2);
                        if (lines_dec != 8'd0)
                            job.kind = JOB_PIX_NEXT;
                        else
                        begin
                            job.kind      = JOB_PIX_END;
                            updating_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                job.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg   <= LINE_BYTES_RST;
            panel_height_reg <= PANEL_HEIGHT_RST;
            updating_reg     <= 1'b0;
            current_line_reg <= 8'd0;
            lines_left_reg   <= 8'd0;
            byte_in_line_reg <= 8'd0;
        end
        else
        begin
            line_bytes_reg   <= line_bytes_next;
            panel_height_reg <= panel_height_next;
            if (push)
            begin
                updating_reg     <= updating_next;
                current_line_reg <= current_line_next;
                lines_left_reg   <= lines_left_next;
                byte_in_line_reg <= byte_in_line_next;
            end
        end
    end

    `ASSERT_NEXT(a_start_enters_update, clk, rst_n, push && job.kind == JOB_START, updating_reg)
    `ASSERT_NEXT(a_last_line_ends_update, clk, rst_n, push && job.kind == JOB_PIX_END, !updating_reg)

endmodule

// ===== hdl/lcdfr_queue.sv =====
// Short job queue between the front and back parts of the framer.
// Depends on lcdfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcdfr_queue
    import lcdfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    `ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full)
    `ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid)

endmodule

// ===== hdl/lcdfr_back.sv =====
// Back part of the framer: expands each queued job into its serial bytes.
// Depends on lcdfr_pkg and assert_macros.svh; drives the registered output stage.
`include "assert_macros.svh"

module lcdfr_back
    import lcdfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_wire_byte,
    output logic       out_byte_valid,
    output logic       out_chip_select,
    output logic       out_last,
    output logic [1:0] out_status
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       bv_reg;
    logic       cs_reg;
    logic       last_reg;
    logic [1:0] status_reg;

    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;
    logic       sel_sent;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == job_len(head_job.kind) - 2'd1);
    assign pop     = load && is_last;

    always_comb
    begin
        sel_sent = 1'b1;
        sel_byte = CODE_DUMMY;
        unique case (head_job.kind)
            JOB_FAIL:
            begin
                sel_sent = 1'b0;
                sel_byte = CODE_DUMMY;
            end
            JOB_CLEAR:
                sel_byte = (idx_reg == 2'd0) ? CODE_CLEAR : CODE_DUMMY;
            JOB_START:
                sel_byte = (idx_reg == 2'd0) ? CODE_WRITE : head_job.addr;
            JOB_PIX:
                sel_byte = head_job.data;
            JOB_PIX_NEXT:
            begin
                if (idx_reg == 2'd0)
                    sel_byte = head_job.data;
                else if (idx_reg == 2'd1)
                    sel_byte = CODE_DUMMY;
                else
                    sel_byte = head_job.addr;
            end
            JOB_PIX_END:
                sel_byte = (idx_reg == 2'd0) ? head_job.data : CODE_DUMMY;
            default:
            begin
                sel_sent = 1'b0;
                sel_byte = CODE_DUMMY;
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= sel_byte;
            bv_reg     <= sel_sent;
            cs_reg     <= sel_sent;
            last_reg   <= is_last;
            status_reg <= head_job.status;
        end
    end

    assign out_valid       = valid_reg;
    assign out_wire_byte   = byte_reg;
    assign out_byte_valid  = bv_reg;
    assign out_chip_select = cs_reg;
    assign out_last        = last_reg;
    assign out_status      = status_reg;

    `ASSERT_IMPL(a_index_in_job, clk, rst_n, head_valid, idx_reg < job_len(head_job.kind))

endmodule

// ===== hdl/memory_lcd_line_framer.sv =====
// Memory LCD line framer, top level. An item is accepted in any cycle the job queue has room;
// its job is stored in a queue slot, and its first result is shown from the output register.
// Results leave one per cycle while the sink takes them, and an item gives 1 to 3 results:
// a mid-line pixel byte or a rejected item 1, a clear or start 2, a line end 3; the output
// register in the back part sets that rate. Reset (rst_n, async, low) empties the queue, leaves
// the panel idle and loads line_bytes 50, panel_height 240. Uses lcdfr_pkg and the lcdfr modules.

module memory_lcd_line_framer
    import lcdfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: index 0 line_bytes, index 1 panel_height.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    // Command items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: region_x[15:0], region_w[31:16], start_line[39:32],
    // line_count[47:40], byte_total[63:48], pixel_byte[71:64]
    input  logic [71:0] s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,

    // Serial byte items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: wire_byte[7:0], byte_valid[8], chip_select[9], zero fill[15:10]
    output logic [15:0] m_tdata,
    // tuser: status[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    // Front-to-queue and queue-to-back job traffic.
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic head_valid;
    job_t head_job;

    logic [7:0] wire_byte;
    logic       byte_valid;
    logic       chip_select;

    // The front part owns every piece of state that the model changes: it checks each
    // command against the region rules and the current update, and hands the back part a
    // compact job that already carries the pixel byte and the bit-reversed gate address.
    lcdfr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_cmd        (cmd_t'(s_tuser)),
        .in_region_x   (s_tdata[15:0]),
        .in_region_w   (s_tdata[31:16]),
        .in_start_line (s_tdata[39:32]),
        .in_line_count (s_tdata[47:40]),
        .in_byte_total (s_tdata[63:48]),
        .in_pixel_byte (s_tdata[71:64]),
        .full          (full),
        .push          (push),
        .push_job      (push_job)
    );

    // The queue lets the front keep taking items while the back is still emitting the
    // trailer and address bytes of a line end, or while the sink stalls.
    lcdfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // The back part walks through the results of the head job, one per cycle while the
    // sink takes them, and retires the job when its final result enters the output register.
    lcdfr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_job        (head_job),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_wire_byte   (wire_byte),
        .out_byte_valid  (byte_valid),
        .out_chip_select (chip_select),
        .out_last        (m_tlast),
        .out_status      (m_tuser)
    );

    assign m_tdata = {6'd0, chip_select, byte_valid, wire_byte};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for memory_lcd_line_framer: a directed table, then random traffic.
// Depends on lcdfr_pkg and the framer RTL only; results are checked against an in-bench model.

module tb;
    import lcdfr_pkg::*;

    // The run is cut off here even if the bench is still waiting for results.
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 7;
    localparam int RAND_ITEMS_PER_PHASE = 38;

    // One serial byte item as it leaves the framer.
    typedef struct packed {
        logic [7:0] wire_byte;
        logic       byte_valid;
        logic       chip_select;
        logic       last;
        status_t    status;
    } wire_item_t;

    // One row of the directed table. A row is either a register write or a command item.
    // For a command item, n_typed selects the expectation: 0 means the in-bench model
    // decides, 1 means a single refusal with status st, 2 means two good bytes b0 then b1.
    typedef struct packed {
        logic        is_cfg;
        cfg_reg_t    reg_id;
        logic [7:0]  reg_val;
        cmd_t        cmd;
        logic [15:0] rx;
        logic [15:0] rw;
        logic [7:0]  y;
        logic [7:0]  h;
        logic [15:0] total;
        logic [7:0]  pix;
        logic [1:0]  n_typed;
        logic [7:0]  b0;
        logic [7:0]  b1;
        status_t     st;
    } step_row_t;

    localparam int N_ROWS = 29;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = 72'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    memory_lcd_line_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bench copy of the framer: registers and update state, all as after reset.
    logic [7:0] cfg_lb = LINE_BYTES_RST;
    logic [7:0] cfg_ph = PANEL_HEIGHT_RST;
    logic       upd_active = 1'b0;
    logic [7:0] gate_line = 8'd0;
    logic [7:0] gates_left = 8'd0;
    logic [7:0] col_count = 8'd0;

    // Serial bytes still owed by the framer, oldest first.
    wire_item_t wire_due[$];

    int  fails = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  steady_send = 1'b0;
    bit  steady_sink = 1'b0;

    // A rejected item gives one result that carries nothing but the status code.
    function automatic wire_item_t refusal(input status_t s);
        return '{8'h00, 1'b0, 1'b0, 1'b1, s};
    endfunction

    // Works out the serial bytes that one command item produces and advances the
    // bench state the same way the framer should. Returns the number of bytes.
    function automatic int frame_command(input cmd_t c, input logic [15:0] rx,
                                         input logic [15:0] rw, input logic [7:0] y,
                                         input logic [7:0] h, input logic [15:0] total,
                                         input logic [7:0] pix, output wire_item_t o [3]);
        logic [7:0] nxt;
        logic [7:0] addr;
        o[0] = '0;
        o[1] = '0;
        o[2] = '0;
        case (c)
            CMD_CLEAR:
            begin
                // A clear in the middle of an update is refused and the update goes on.
                if (upd_active)
                begin
                    o[0] = refusal(ST_INVALID);
                    return 1;
                end
                o[0] = '{CODE_CLEAR, 1'b1, 1'b1, 1'b0, ST_OK};
                o[1] = '{CODE_DUMMY, 1'b1, 1'b1, 1'b1, ST_OK};
                return 2;
            end
            CMD_START:
            begin
                // The region checks run in a fixed order; the first one that fails wins.
                if (upd_active || h == 8'd0 || int'(h) > MAX_LINES || cfg_lb == 8'd0)
                begin
                    o[0] = refusal(ST_INVALID);
                    return 1;
                end
                if (rx != 16'd0 || rw != 16'(cfg_lb) * 16'd8)
                begin
                    o[0] = refusal(ST_UNSUPPORTED);
                    return 1;
                end
                if ({1'b0, y} + {1'b0, h} > {1'b0, cfg_ph} ||
                    total != 16'(h) * 16'(cfg_lb))
                begin
                    o[0] = refusal(ST_INVALID);
                    return 1;
                end
                upd_active = 1'b1;
                gate_line = y;
                gates_left = h;
                col_count = 8'd0;
                nxt = y + 8'd1;
                addr = {<<{nxt}};
                o[0] = '{CODE_WRITE, 1'b1, 1'b1, 1'b0, ST_OK};
                o[1] = '{addr, 1'b1, 1'b1, 1'b1, ST_OK};
                return 2;
            end
            CMD_PIXEL:
            begin
                if (!upd_active)
                begin
                    o[0] = refusal(ST_INVALID);
                    return 1;
                end
                // The line closes once the count reaches the register, or has gone past
                // it because line_bytes was lowered during the update.
                col_count = col_count + 8'd1;
                if (col_count < cfg_lb)
                begin
                    o[0] = '{pix, 1'b1, 1'b1, 1'b1, ST_OK};
                    return 1;
                end
                o[0] = '{pix, 1'b1, 1'b1, 1'b0, ST_OK};
                o[1] = '{CODE_DUMMY, 1'b1, 1'b1, 1'b0, ST_OK};
                col_count = 8'd0;
                gates_left = gates_left - 8'd1;
                gate_line = gate_line + 8'd1;
                if (gates_left != 8'd0)
                begin
                    nxt = gate_line + 8'd1;
                    addr = {<<{nxt}};
                    o[2] = '{addr, 1'b1, 1'b1, 1'b1, ST_OK};
                end
                else
                begin
                    o[2] = '{CODE_DUMMY, 1'b1, 1'b1, 1'b1, ST_OK};
                    upd_active = 1'b0;
                end
                return 3;
            end
            default:
            begin
                o[0] = refusal(ST_INVALID);
                return 1;
            end
        endcase
    endfunction

    // Sender idle time before the next item: usually none or a little, now and then long.
    // In a steady stretch the sender never idles.
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_send || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one command item, holds it until the framer takes it, and then records the
    // bytes it is owed. tvalid is left high so that the next item can follow back to back.
    task automatic send_item(input cmd_t c, input logic [15:0] rx, input logic [15:0] rw,
                             input logic [7:0] y, input logic [7:0] h,
                             input logic [15:0] total, input logic [7:0] pix,
                             input logic [1:0] n_typed, input logic [7:0] b0,
                             input logic [7:0] b1, input status_t st);
        int gap;
        int n;
        wire_item_t res [3];
        if ($urandom_range(0, 39) == 0)
            steady_send = !steady_send;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {pix, total, h, y, rw, rx};
        do
            @(posedge clk);
        while (!s_tready);
        // Accepted at this edge. The model always runs so that its state follows along;
        // a row with a typed expectation replaces what the model would have queued.
        n = frame_command(c, rx, rw, y, h, total, pix, res);
        if (n_typed == 2'd1)
        begin
            n = 1;
            res[0] = refusal(st);
        end
        else if (n_typed == 2'd2)
        begin
            n = 2;
            res[0] = '{b0, 1'b1, 1'b1, 1'b0, ST_OK};
            res[1] = '{b1, 1'b1, 1'b1, 1'b1, ST_OK};
        end
        for (int i = 0; i < n; i++)
            wire_due.push_back(res[i]);
    endtask

    // Registers are only written with nothing in flight: the sender stops, every owed
    // byte has to come out, and a few more cycles pass before the write.
    task automatic write_reg(input cfg_reg_t id, input logic [7:0] val);
        s_tvalid <= 1'b0;
        while (wire_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= id;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (id == REG_LINE_BYTES)
            cfg_lb = val;
        else
            cfg_ph = val;
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        fails++;
        if (fails <= 30)
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    endtask

    // Directed part. It starts from the reset registers (50 bytes per line, 240 lines),
    // walks every refusal of a start, a short two-line update with the byte extremes, the
    // last gate line at the largest panel, a zero line_bytes, and a line that ends early
    // because line_bytes was lowered halfway through it.
    step_row_t directed_rows [N_ROWS] = '{
        // Pixel byte with no update running, then the reserved command with every field but y all ones.
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'hFF,
          2'd1, 8'h00, 8'h00, ST_INVALID},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_RSVD, 16'hFFFF, 16'hFFFF, 8'd254, 8'hFF, 16'hFFFF,
          8'hFF, 2'd1, 8'h00, 8'h00, ST_INVALID},
        // Clear while idle.
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd2, CODE_CLEAR, CODE_DUMMY, ST_OK},
        // Region not at column zero, then width one pixel short of the line.
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd1, 16'd400, 8'd0, 8'd1, 16'd50, 8'h00,
          2'd1, 8'h00, 8'h00, ST_UNSUPPORTED},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd399, 8'd0, 8'd1, 16'd50, 8'h00,
          2'd1, 8'h00, 8'h00, ST_UNSUPPORTED},
        // No lines, one line past the panel bottom, byte total one short.
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd400, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd1, 8'h00, 8'h00, ST_INVALID},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd400, 8'd200, 8'd41, 16'd2050,
          8'h00, 2'd1, 8'h00, 8'h00, ST_INVALID},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd400, 8'd0, 8'd1, 16'd49, 8'h00,
          2'd1, 8'h00, 8'h00, ST_INVALID},
        // Two bytes per line; a two-line update from the top of the panel.
        '{1'b1, REG_LINE_BYTES, 8'd2, CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd16, 8'd0, 8'd2, 16'd4, 8'h00,
          2'd2, CODE_WRITE, 8'h80, ST_OK},
        // A second start and a clear are both refused while the update runs.
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd16, 8'd0, 8'd2, 16'd4, 8'h00,
          2'd1, 8'h00, 8'h00, ST_INVALID},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd1, 8'h00, 8'h00, ST_INVALID},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'hFF,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'hA5,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h5A,
          2'd0, 8'h00, 8'h00, ST_OK},
        // Largest panel, one byte per line; the last gate line has the 1-based address
        // 255, so its address byte is all ones.
        '{1'b1, REG_PANEL_HEIGHT, 8'd255, CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b1, REG_LINE_BYTES, 8'd1, CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd8, 8'd254, 8'd1, 16'd1, 8'h00,
          2'd2, CODE_WRITE, 8'hFF, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h3C,
          2'd0, 8'h00, 8'h00, ST_OK},
        // The full 255-line region with a byte total one short.
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd8, 8'd0, 8'd255, 16'd254, 8'h00,
          2'd1, 8'h00, 8'h00, ST_INVALID},
        // Zero bytes per line makes every start invalid.
        '{1'b1, REG_LINE_BYTES, 8'd0, CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd0, 8'd0, 8'd1, 16'd0, 8'h00,
          2'd1, 8'h00, 8'h00, ST_INVALID},
        // Line of four bytes; after two of them line_bytes drops to one, so the next
        // byte closes the line and, being the only line, the update.
        '{1'b1, REG_LINE_BYTES, 8'd4, CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_START, 16'd0, 16'd32, 8'd5, 8'd1, 16'd4, 8'h00,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h11,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h22,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b1, REG_LINE_BYTES, 8'd1, CMD_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h00,
          2'd0, 8'h00, 8'h00, ST_OK},
        '{1'b0, REG_LINE_BYTES, 8'd0, CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 8'h33,
          2'd0, 8'h00, 8'h00, ST_OK}
    };

    // Register settings for the random phases. The 255-byte phase leaves its update
    // open, so the next phase with two bytes per line closes that line on the first
    // byte; the zero phase refuses every start and ends a line on every pixel byte.
    logic [7:0] lb_plan [RAND_PHASES] = '{8'd3, 8'd1, 8'd255, 8'd2, 8'd5, 8'd0, 8'd4};
    logic [7:0] ph_plan [RAND_PHASES] = '{8'd16, 8'd255, 8'd8, 8'd1, 8'd255, 8'd40, 8'd100};

    // Stimulus.
    initial
    begin : stimulus
        cmd_t        c;
        logic [15:0] rx;
        logic [15:0] rw;
        logic [7:0]  y;
        logic [7:0]  h;
        logic [15:0] total;
        logic [7:0]  pix;
        int          roll;
        int          hmax;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].reg_id, directed_rows[i].reg_val);
            else
                send_item(directed_rows[i].cmd, directed_rows[i].rx, directed_rows[i].rw,
                          directed_rows[i].y, directed_rows[i].h, directed_rows[i].total,
                          directed_rows[i].pix, directed_rows[i].n_typed,
                          directed_rows[i].b0, directed_rows[i].b1, directed_rows[i].st);
        end

        // Random part. Most items are either pixel bytes of a running update or
        // well-formed starts for the current registers; the rest are clears, broken
        // starts and items with every field random.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_reg(REG_LINE_BYTES, lb_plan[p]);
            write_reg(REG_PANEL_HEIGHT, ph_plan[p]);
            for (int k = 0; k < RAND_ITEMS_PER_PHASE; k++)
            begin
                roll = $urandom_range(0, 99);
                c = cmd_t'($urandom_range(0, 3));
                rx = 16'($urandom_range(0, 65535));
                rw = 16'($urandom_range(0, 65535));
                y = 8'($urandom_range(0, 254));
                h = 8'($urandom_range(0, 255));
                total = 16'($urandom_range(0, 65535));
                pix = 8'($urandom_range(0, 255));
                if (upd_active && roll < 80)
                begin
                    c = CMD_PIXEL;
                end
                else if (!upd_active && roll < 60)
                begin
                    c = CMD_START;
                    rx = 16'd0;
                    y = 8'($urandom_range(0, int'(cfg_ph) - 1));
                    hmax = int'(cfg_ph) - int'(y);
                    if (hmax > 3)
                        hmax = 3;
                    h = 8'($urandom_range(1, hmax));
                    rw = 16'(cfg_lb) * 16'd8;
                    total = 16'(h) * 16'(cfg_lb);
                    // About one start in four is broken in exactly one field.
                    if ($urandom_range(0, 3) == 0)
                    begin
                        case ($urandom_range(0, 4))
                            0: rx = 16'($urandom_range(1, 65535));
                            1: rw = rw ^ (16'd1 << $urandom_range(0, 15));
                            2: total = total + 16'($urandom_range(1, 300));
                            3: h = 8'd0;
                            default: h = 8'(int'(cfg_ph) - int'(y) + 1);
                        endcase
                    end
                end
                else if (!upd_active && roll < 72)
                begin
                    c = CMD_CLEAR;
                end
                send_item(c, rx, rw, y, h, total, pix, 2'd0, 8'h00, 8'h00, ST_OK);
            end
        end

        // Finish any update still open so that the panel ends idle.
        while (upd_active)
            send_item(CMD_PIXEL, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0,
                      8'($urandom_range(0, 255)), 2'd0, 8'h00, 8'h00, ST_OK);
        s_tvalid <= 1'b0;

        // Wait for every owed byte, then a little longer to catch any stray one.
        while (wire_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Output side: checks each accepted serial byte against the oldest owed one and
    // drives tready with random stalls, short ones mostly, some long, and stretches
    // where it never stalls.
    always @(posedge clk)
    begin : sink_side
        wire_item_t want;
        if (m_tvalid && m_tready)
        begin
            if (wire_due.size() == 0)
            begin
                fails++;
                if (fails <= 30)
                    $display("%0t: unexpected item, expected none, got tdata %h tuser %h last %b",
                             $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = wire_due.pop_front();
                if (m_tdata[7:0] !== want.wire_byte)
                    note_mismatch("wire_byte", want.wire_byte, m_tdata[7:0]);
                if (m_tdata[8] !== want.byte_valid)
                    note_mismatch("byte_valid", want.byte_valid, m_tdata[8]);
                if (m_tdata[9] !== want.chip_select)
                    note_mismatch("chip_select", want.chip_select, m_tdata[9]);
                if (m_tdata[15:10] !== 6'd0)
                    note_mismatch("tdata zero fill", 0, m_tdata[15:10]);
                if (m_tlast !== want.last)
                    note_mismatch("last", want.last, m_tlast);
                if (m_tuser !== want.status)
                    note_mismatch("status", want.status, m_tuser);
            end
        end

        if ($urandom_range(0, 199) == 0)
            steady_sink = !steady_sink;
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!steady_sink && $urandom_range(0, 3) == 0)
            begin
                roll_stall : begin
                    int r;
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        stall_left = $urandom_range(1, 2);
                    else if (r < 95)
                        stall_left = $urandom_range(3, 6);
                    else
                        stall_left = $urandom_range(15, 40);
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lcdfr_pkg.sv
hdl/lcdfr_front.sv
hdl/lcdfr_queue.sv
hdl/lcdfr_back.sv
hdl/memory_lcd_line_framer.sv
sim/tb.sv
